FILE: rtl/core/fgq_pkg.sv
// Shared types, codes and default sizes for the feature grid area query block.
// Used by every other module under rtl/core but fgq_ram; depends on nothing.
package fgq_pkg;

    localparam int MAX_POINTS_DEF       = 2048;
    localparam int MAX_GRID_COLUMNS_DEF = 64;
    localparam int MAX_GRID_ROWS_DEF    = 64;
    localparam int MAX_HITS_DEF         = 64;

    localparam int COORD_W    = 16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GRID_IDX_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_HIT      = 3'd1,
        ST_NO_HITS  = 3'd2,
        ST_OUTSIDE  = 3'd3,
        ST_FULL     = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GRID_COLUMNS   = 3'd0,
        CFG_GRID_ROWS      = 3'd1,
        CFG_CELL_SIZE_LOG2 = 3'd2,
        CFG_ORIGIN_X       = 3'd3,
        CFG_ORIGIN_Y       = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_OUTSIDE,
        OP_QUERY,
        OP_NO_HITS,
        OP_CLEAR
    } op_kind_t;

    typedef enum logic [3:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_INS_RD,
        BK_INS_WR,
        BK_Q_CELL,
        BK_Q_HEAD,
        BK_Q_PT,
        BK_Q_END,
        BK_RESULT
    } back_state_t;

    typedef struct packed {
        logic [6:0]         grid_columns;
        logic [6:0]         grid_rows;
        logic [2:0]         cell_size_log2;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
    } grid_cfg_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        op_kind_t              kind;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [COORD_W-1:0]    radius;
        logic [GRID_IDX_W-1:0] col_lo;
        logic [GRID_IDX_W-1:0] col_hi;
        logic [GRID_IDX_W-1:0] row_lo;
        logic [GRID_IDX_W-1:0] row_hi;
    } op_t;

endpackage

FILE: rtl/core/feature_grid_area_query.sv
// Top level of the feature grid area query block: configuration registers,
// front end classifier with command queue, and back end list engine.
// Depends on fgq_pkg, fgq_front, fgq_back, fgq_ram.
//
// Usage. Commands arrive as beats on the s_ channel: s_tuser carries the
// command (insert, query, clear), s_tdata carries pos_x, pos_y and radius.
// Results leave as beats on the m_ channel: m_tuser carries status and the
// truncated flag, m_tdata the feature index, m_tlast marks the final result
// of a command. Every command except the unused code gives at least one beat.
// The front end classifies a command in the accepting cycle and parks it in
// a two-entry queue, so commands keep flowing in while the back end works.
// With the back end idle, an insert passes from the queue through BK_INS_RD,
// BK_INS_WR and BK_RESULT to its result beat, and an outside, full or
// empty-window command goes from the queue straight to BK_RESULT. A query
// visits each cell of its clipped window in BK_Q_CELL and BK_Q_HEAD, then each
// stored point of an occupied cell in BK_Q_PT; the linked point list, read
// through one registered memory port, sets that pace. A clear, and likewise
// reset, sweeps every cell of the cell head memory, one cell per cycle, before the
// next command is taken; configuration writes are accepted at any time.
// When the receiver holds m_tready low, the result register holds its beat
// and the back end waits; the queue then fills and s_tready drops.
module feature_grid_area_query
    import fgq_pkg::*;
#(
    parameter int MAX_POINTS       = MAX_POINTS_DEF,
    parameter int MAX_GRID_COLUMNS = MAX_GRID_COLUMNS_DEF,
    parameter int MAX_GRID_ROWS    = MAX_GRID_ROWS_DEF,
    parameter int MAX_HITS         = MAX_HITS_DEF,
    localparam int TDW = (($clog2(MAX_POINTS) + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [3*COORD_W-1:0]  s_tdata,   // pos_x, pos_y, radius
    input  logic [CMD_W-1:0]      s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDW-1:0]        m_tdata,   // feature_index, zero filled
    output logic                  m_tlast,
    output logic [STATUS_W:0]     m_tuser    // status, truncated
);

    grid_cfg_t cfg_reg;
    logic      op_valid, op_ready;
    op_t       op;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_columns   <= 7'd20;
            cfg_reg.grid_rows      <= 7'd15;
            cfg_reg.cell_size_log2 <= 3'd5;
            cfg_reg.origin_x       <= '0;
            cfg_reg.origin_y       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_GRID_COLUMNS:   cfg_reg.grid_columns   <= cfg_wdata[6:0];
                CFG_GRID_ROWS:      cfg_reg.grid_rows      <= cfg_wdata[6:0];
                CFG_CELL_SIZE_LOG2: cfg_reg.cell_size_log2 <= cfg_wdata[2:0];
                CFG_ORIGIN_X:       cfg_reg.origin_x       <= cfg_wdata;
                CFG_ORIGIN_Y:       cfg_reg.origin_y       <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Classifies each command against the current grid and queues it.
    fgq_front #(
        .MAX_GRID_COLUMNS(MAX_GRID_COLUMNS),
        .MAX_GRID_ROWS(MAX_GRID_ROWS)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .op_valid(op_valid), .op_ready(op_ready), .op(op));

    // Executes commands on the point store and produces result beats.
    fgq_back #(
        .MAX_POINTS(MAX_POINTS),
        .MAX_GRID_COLUMNS(MAX_GRID_COLUMNS),
        .MAX_GRID_ROWS(MAX_GRID_ROWS),
        .MAX_HITS(MAX_HITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .op_valid(op_valid), .op_ready(op_ready), .op(op),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser));

endmodule

FILE: rtl/core/fgq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module fgq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/fgq_front.sv
// Front end: accepts input beats, bins inserts and clips query windows to cell
// ranges, and queues the classified commands. Depends on fgq_pkg.
module fgq_front
    import fgq_pkg::*;
#(
    parameter int MAX_GRID_COLUMNS = MAX_GRID_COLUMNS_DEF,
    parameter int MAX_GRID_ROWS    = MAX_GRID_ROWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  grid_cfg_t            cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [3*COORD_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 op_valid,
    input  logic                 op_ready,
    output op_t                  op
);

    logic [COORD_W-1:0] pos_x, pos_y, radius;
    logic [3:0]         shamt;
    logic [8:0]         eff_cols, eff_rows;
    logic [COORD_W-1:0] rel_x, rel_y, cell_x, cell_y;
    logic               outside;
    logic signed [19:0] rnd;
    logic signed [19:0] rq_x, lo_x, hi_x, fl_x, cl_x, min_x, max_x, lim_x;
    logic signed [19:0] rq_y, lo_y, hi_y, fl_y, cl_y, min_y, max_y, lim_y;
    logic               empty;
    op_t                op_in;
    logic               push, pop;

    op_t  fifo_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign pos_x  = s_tdata[COORD_W-1:0];
    assign pos_y  = s_tdata[2*COORD_W-1:COORD_W];
    assign radius = s_tdata[3*COORD_W-1:2*COORD_W];

    always_comb
    begin
        shamt    = {1'b0, cfg.cell_size_log2} + 4'd4;
        eff_cols = (9'(cfg.grid_columns) > 9'(MAX_GRID_COLUMNS)) ?
                   9'(MAX_GRID_COLUMNS) : 9'(cfg.grid_columns);
        eff_rows = (9'(cfg.grid_rows) > 9'(MAX_GRID_ROWS)) ?
                   9'(MAX_GRID_ROWS) : 9'(cfg.grid_rows);

        // Insert binning.
        rel_x   = pos_x - cfg.origin_x;
        rel_y   = pos_y - cfg.origin_y;
        cell_x  = rel_x >> shamt;
        cell_y  = rel_y >> shamt;
        outside = (pos_x < cfg.origin_x) || (pos_y < cfg.origin_y) ||
                  (cell_x >= 16'(eff_cols)) || (cell_y >= 16'(eff_rows));

        // Query window: floor of the low edge, ceiling of the high edge.
        rnd   = $signed((20'd1 << shamt) - 20'd1);
        rq_x  = $signed({4'b0, pos_x}) - $signed({4'b0, cfg.origin_x});
        rq_y  = $signed({4'b0, pos_y}) - $signed({4'b0, cfg.origin_y});
        lo_x  = rq_x - $signed({4'b0, radius});
        hi_x  = rq_x + $signed({4'b0, radius});
        lo_y  = rq_y - $signed({4'b0, radius});
        hi_y  = rq_y + $signed({4'b0, radius});
        fl_x  = lo_x >>> shamt;
        cl_x  = (hi_x + rnd) >>> shamt;
        fl_y  = lo_y >>> shamt;
        cl_y  = (hi_y + rnd) >>> shamt;
        lim_x = $signed({11'b0, eff_cols}) - 20'sd1;
        lim_y = $signed({11'b0, eff_rows}) - 20'sd1;
        min_x = (fl_x < 20'sd0) ? 20'sd0 : fl_x;
        max_x = (cl_x > lim_x) ? lim_x : cl_x;
        min_y = (fl_y < 20'sd0) ? 20'sd0 : fl_y;
        max_y = (cl_y > lim_y) ? lim_y : cl_y;
        empty = (min_x > max_x) || (min_y > max_y);

        op_in.x      = pos_x;
        op_in.y      = pos_y;
        op_in.radius = radius;
        op_in.col_lo = min_x[GRID_IDX_W-1:0];
        op_in.col_hi = max_x[GRID_IDX_W-1:0];
        op_in.row_lo = min_y[GRID_IDX_W-1:0];
        op_in.row_hi = max_y[GRID_IDX_W-1:0];
        unique case (cmd_t'(s_tuser))
            CMD_INSERT:
            begin
                op_in.kind   = outside ? OP_OUTSIDE : OP_INSERT;
                op_in.col_lo = cell_x[GRID_IDX_W-1:0];
                op_in.row_lo = cell_y[GRID_IDX_W-1:0];
            end
            CMD_QUERY: op_in.kind = empty ? OP_NO_HITS : OP_QUERY;
            default:   op_in.kind = OP_CLEAR;
        endcase
    end

    // Two-entry queue between the front and back ends.
    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready && (cmd_t'(s_tuser) != CMD_NONE);
    assign op_valid = (cnt_reg != 2'd0);
    assign pop      = op_valid && op_ready;
    assign op       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

FILE: rtl/core/fgq_back.sv
// Back end: owns the point and cell list memories, appends inserts, walks
// query cell ranges and drives the result register. Depends on fgq_pkg, fgq_ram.
module fgq_back
    import fgq_pkg::*;
#(
    parameter int MAX_POINTS       = MAX_POINTS_DEF,
    parameter int MAX_GRID_COLUMNS = MAX_GRID_COLUMNS_DEF,
    parameter int MAX_GRID_ROWS    = MAX_GRID_ROWS_DEF,
    parameter int MAX_HITS         = MAX_HITS_DEF,
    localparam int PW     = $clog2(MAX_POINTS),
    localparam int TDW    = ((PW + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  op_t                 op,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDW-1:0]      m_tdata,
    output logic                m_tlast,
    output logic [STATUS_W:0]   m_tuser
);

    localparam int NCELLS = MAX_GRID_COLUMNS * MAX_GRID_ROWS;
    localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int HW     = $clog2(MAX_HITS + 1);

    back_state_t           state_reg, state_next;
    logic [CW-1:0]         sweep_reg, sweep_next;
    logic                  clr_reg, clr_next;
    op_t                   op_reg, op_next;
    logic [PW:0]           count_reg, count_next;
    logic [GRID_IDX_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [PW-1:0]         cur_reg, cur_next, tail_reg, tail_next;
    logic [HW-1:0]         hits_reg, hits_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [PW-1:0]         pend_idx_reg, pend_idx_next;
    status_t               res_status_reg, res_status_next;
    logic [PW-1:0]         res_idx_reg, res_idx_next;
    logic                  res_last_reg, res_last_next, res_trunc_reg, res_trunc_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [PW-1:0]         out_idx_reg, out_idx_next;
    logic                  out_last_reg, out_last_next, out_trunc_reg, out_trunc_next;

    logic [CW-1:0]         cell_addr;
    logic                  pts_we, nxt_we, head_we, tail_we;
    logic [PW-1:0]         pts_raddr;
    logic [CW-1:0]         head_waddr;
    logic [PW:0]           head_wdata;
    logic [2*COORD_W-1:0]  pts_rd;
    logic [PW-1:0]         nxt_rd, tail_rd;
    logic [PW:0]           head_rd;
    logic [PW-1:0]         new_idx;
    logic [COORD_W-1:0]    dx, dy;
    logic                  match, slot_free;
    back_state_t           adv_state;
    logic [GRID_IDX_W-1:0] adv_col, adv_row;

    assign cell_addr = CW'({8'd0, row_reg} * 16'(MAX_GRID_COLUMNS) + {8'd0, col_reg});
    assign new_idx   = count_reg[PW-1:0];

    fgq_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_pts (
        .clk(clk), .we(pts_we), .waddr(new_idx), .wdata({op_reg.y, op_reg.x}),
        .raddr(pts_raddr), .rdata(pts_rd));

    fgq_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_nxt (
        .clk(clk), .we(nxt_we), .waddr(tail_rd), .wdata(new_idx),
        .raddr(pts_raddr), .rdata(nxt_rd));

    fgq_ram #(.WIDTH(PW + 1), .DEPTH(NCELLS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(cell_addr), .rdata(head_rd));

    fgq_ram #(.WIDTH(PW), .DEPTH(NCELLS)) u_tail (
        .clk(clk), .we(tail_we), .waddr(cell_addr), .wdata(new_idx),
        .raddr(cell_addr), .rdata(tail_rd));

    always_comb
    begin
        dx    = (pts_rd[COORD_W-1:0] >= op_reg.x) ? pts_rd[COORD_W-1:0] - op_reg.x
                                                  : op_reg.x - pts_rd[COORD_W-1:0];
        dy    = (pts_rd[2*COORD_W-1:COORD_W] >= op_reg.y) ?
                pts_rd[2*COORD_W-1:COORD_W] - op_reg.y : op_reg.y - pts_rd[2*COORD_W-1:COORD_W];
        match = (dx < op_reg.radius) && (dy < op_reg.radius);

        // Column-major walk: rows advance first, then the column.
        adv_col   = col_reg;
        adv_row   = row_reg + 8'd1;
        adv_state = BK_Q_CELL;
        if (row_reg == op_reg.row_hi)
        begin
            adv_row = op_reg.row_lo;
            adv_col = col_reg + 8'd1;
            if (col_reg == op_reg.col_hi)
            begin
                adv_state = BK_Q_END;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cur_next        = cur_reg;
        tail_next       = tail_reg;
        hits_next       = hits_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_last_next   = res_last_reg;
        res_trunc_next  = res_trunc_reg;
        slot_free       = !out_valid_reg || m_tready;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        out_trunc_next  = out_trunc_reg;
        op_ready        = 1'b0;
        pts_we          = 1'b0;
        nxt_we          = 1'b0;
        head_we         = 1'b0;
        tail_we         = 1'b0;
        head_waddr      = cell_addr;
        head_wdata      = {1'b1, new_idx};
        pts_raddr       = cur_reg;

        unique case (state_reg)
            BK_SWEEP:
            begin
                head_we    = 1'b1;
                head_waddr = sweep_reg;
                head_wdata = '0;
                sweep_next = sweep_reg + CW'(1);
                if (sweep_reg == CW'(NCELLS - 1))
                begin
                    sweep_next      = '0;
                    res_status_next = ST_CLEARED;
                    res_idx_next    = '0;
                    res_last_next   = 1'b1;
                    res_trunc_next  = 1'b0;
                    state_next      = clr_reg ? BK_RESULT : BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    op_next         = op;
                    col_next        = op.col_lo;
                    row_next        = op.row_lo;
                    hits_next       = '0;
                    pend_valid_next = 1'b0;
                    res_idx_next    = '0;
                    res_last_next   = 1'b1;
                    res_trunc_next  = 1'b0;
                    unique case (op.kind)
                        OP_INSERT:
                        begin
                            if (count_reg == (PW+1)'(MAX_POINTS))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = BK_RESULT;
                            end
                            else
                            begin
                                state_next = BK_INS_RD;
                            end
                        end
                        OP_OUTSIDE:
                        begin
                            res_status_next = ST_OUTSIDE;
                            state_next      = BK_RESULT;
                        end
                        OP_NO_HITS:
                        begin
                            res_status_next = ST_NO_HITS;
                            state_next      = BK_RESULT;
                        end
                        OP_QUERY: state_next = BK_Q_CELL;
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            clr_next   = 1'b1;
                            state_next = BK_SWEEP;
                        end
                        default: state_next = BK_IDLE;
                    endcase
                end
            end
            BK_INS_RD: state_next = BK_INS_WR;
            BK_INS_WR:
            begin
                pts_we  = 1'b1;
                tail_we = 1'b1;
                if (head_rd[PW])
                begin
                    nxt_we = 1'b1;
                end
                else
                begin
                    head_we = 1'b1;
                end
                count_next      = count_reg + (PW+1)'(1);
                res_status_next = ST_INSERTED;
                res_idx_next    = new_idx;
                state_next      = BK_RESULT;
            end
            BK_Q_CELL: state_next = BK_Q_HEAD;
            BK_Q_HEAD:
            begin
                if (head_rd[PW])
                begin
                    cur_next   = head_rd[PW-1:0];
                    tail_next  = tail_rd;
                    pts_raddr  = head_rd[PW-1:0];
                    state_next = BK_Q_PT;
                end
                else
                begin
                    col_next   = adv_col;
                    row_next   = adv_row;
                    state_next = adv_state;
                end
            end
            BK_Q_PT:
            begin
                if (match && (hits_reg == HW'(MAX_HITS)))
                begin
                    // One match beyond the cap: close the run on the held hit.
                    res_status_next = ST_HIT;
                    res_idx_next    = pend_idx_reg;
                    res_last_next   = 1'b1;
                    res_trunc_next  = 1'b1;
                    state_next      = BK_RESULT;
                end
                else if (!(match && pend_valid_reg && !slot_free))
                begin
                    if (match)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_HIT;
                            out_idx_next    = pend_idx_reg;
                            out_last_next   = 1'b0;
                            out_trunc_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = cur_reg;
                        hits_next       = hits_reg + HW'(1);
                    end
                    if (cur_reg == tail_reg)
                    begin
                        col_next   = adv_col;
                        row_next   = adv_row;
                        state_next = adv_state;
                    end
                    else
                    begin
                        cur_next  = nxt_rd;
                        pts_raddr = nxt_rd;
                    end
                end
            end
            BK_Q_END:
            begin
                res_status_next = pend_valid_reg ? ST_HIT : ST_NO_HITS;
                res_idx_next    = pend_valid_reg ? pend_idx_reg : '0;
                res_last_next   = 1'b1;
                res_trunc_next  = 1'b0;
                state_next      = BK_RESULT;
            end
            BK_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_idx_next    = res_idx_reg;
                    out_last_next   = res_last_reg;
                    out_trunc_next  = res_trunc_reg;
                    clr_next        = 1'b0;
                    state_next      = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_SWEEP;
            sweep_reg      <= '0;
            clr_reg        <= 1'b0;
            count_reg      <= '0;
            hits_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            clr_reg        <= clr_next;
            count_reg      <= count_next;
            hits_reg       <= hits_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        cur_reg        <= cur_next;
        tail_reg       <= tail_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_last_reg   <= res_last_next;
        res_trunc_reg  <= res_trunc_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_last_reg   <= out_last_next;
        out_trunc_reg  <= out_trunc_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'(out_idx_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_trunc_reg, out_status_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(MAX_POINTS))
        else $error("point count beyond store size");

    a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= HW'(MAX_HITS))
        else $error("hit count beyond cap");

    a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (hits_reg != '0))
        else $error("held hit without a hit count");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_INS_WR) |=> (count_reg == $past(count_reg) + (PW+1)'(1)))
        else $error("insert did not advance the point count");

endmodule
